### src/ekvt_pkg.sv
// shared types, constants and codes for the expiring key value table
`default_nettype none
package ekvt_pkg;

    localparam int ENTRIES     = 64;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int TIME_BITS   = 32;
    localparam int IDX_BITS    = $clog2(ENTRIES);
    localparam int CTR_BITS    = IDX_BITS + 1;
    localparam int CNT_BITS    = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [TIME_BITS-1:0] EXPIRY_RESET = TIME_BITS'(120000);

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_FETCH = 2'd1,
        MODE_PURGE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_HIT      = 3'd2,
        ST_MISS     = 3'd3,
        ST_FULL     = 3'd4,
        ST_PURGED   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_FETCH,
        OP_PURGE,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic [1:0]            mode;
        logic [KEY_BITS-1:0]   lookup_key;
        logic [VALUE_BITS-1:0] entry_value;
        logic [TIME_BITS-1:0]  now_ticks;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            status;
        logic [VALUE_BITS-1:0] found_value;
        logic [CNT_BITS-1:0]   purged_count;
    } t_out_item;

    typedef struct packed {
        t_op                   op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [TIME_BITS-1:0]  now;
    } t_cmd;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [TIME_BITS-1:0]  stamp;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

endpackage
`default_nettype wire

### src/expiring_key_value_table.sv
// top level of the expiring key value table
// the back end scans the slot ram one slot per cycle and takes a new command only when idle,
//   so full scans take the longest from input transfer to result
// reset: synchronous, active low; clears all slot valid bits and loads expiry with 120000
`default_nettype none
module expiring_key_value_table (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire ekvt_pkg::t_in_item             i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output ekvt_pkg::t_out_item                 o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [ekvt_pkg::TIME_BITS-1:0] i_cfg_data
);
    import ekvt_pkg::*;

    logic [TIME_BITS-1:0] r_expiry;
    logic                 f_valid;
    logic                 f_ready;
    t_cmd                 f_cmd;
    logic                 q_valid;
    logic                 q_ready;
    t_cmd                 q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= EXPIRY_RESET;
        end else if (i_cfg_we) begin
            r_expiry <= i_cfg_data;
        end
    end

    ekvt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    ekvt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    ekvt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_expiry    (r_expiry),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_value_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_HIT) |-> o_out.found_value == '0)
        else $error("found value set on a result that is not a hit");

    a_count_only_on_purge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_PURGED) |-> o_out.purged_count == '0)
        else $error("purge count set on a result that is not a purge");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.purged_count <= CNT_BITS'(ENTRIES))
        else $error("purge count exceeds table size");

endmodule
`default_nettype wire

### src/ekvt_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module ekvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ABITS = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [ABITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [ABITS-1:0] i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### src/ekvt_front.sv
// front end: takes input transfers and turns each into a command
`default_nettype none
module ekvt_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ekvt_pkg::t_in_item i_in,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_ready,
    output ekvt_pkg::t_cmd         o_cmd
);
    import ekvt_pkg::*;

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd.key   = i_in.lookup_key;
        n_cmd.value = i_in.entry_value;
        n_cmd.now   = i_in.now_ticks;
        unique case (i_in.mode)
            MODE_ADD:   n_cmd.op = OP_ADD;
            MODE_FETCH: n_cmd.op = OP_FETCH;
            MODE_PURGE: n_cmd.op = OP_PURGE;
            default:    n_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_ready  = !r_vld || i_cmd_ready;
    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

### src/ekvt_queue.sv
// short command queue between front and back end
`default_nettype none
module ekvt_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ekvt_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ekvt_pkg::t_cmd      o_cmd
);
    import ekvt_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int FILL_BITS = PTR_BITS + 1;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  r_wptr;
    logic [PTR_BITS-1:0]  r_rptr;
    logic [FILL_BITS-1:0] r_fill;
    logic                 push;
    logic                 pop;

    assign o_ready = r_fill != FILL_BITS'(QUEUE_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_cmd   = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

### src/ekvt_back.sv
// back end: scans the slot table for each add, fetch or purge command and drives the result register
`default_nettype none
module ekvt_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [ekvt_pkg::TIME_BITS-1:0]   i_expiry,
    input  wire logic                             i_cmd_valid,
    output logic                                  o_cmd_ready,
    input  wire ekvt_pkg::t_cmd                   i_cmd,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output ekvt_pkg::t_out_item                   o_out
);
    import ekvt_pkg::*;

    t_bstate                r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [CTR_BITS-1:0]    r_addr, n_addr;
    logic                   r_chk_vld, n_chk_vld;
    logic [IDX_BITS-1:0]    r_chk_idx, n_chk_idx;
    logic                   r_free_vld, n_free_vld;
    logic [IDX_BITS-1:0]    r_free_idx, n_free_idx;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    t_out_item              r_res, n_res;
    logic [ENTRIES-1:0]     r_valid, n_valid;
    logic                   r_out_vld, n_out_vld;
    t_out_item              r_out, n_out;

    logic                   ram_we;
    logic [IDX_BITS-1:0]    ram_waddr;
    t_slot                  ram_wdata;
    logic [IDX_BITS-1:0]    ram_raddr;
    logic [SLOT_BITS-1:0]   ram_rdata;
    t_slot                  rd_slot;

    logic                   chk_live;
    logic                   key_hit;
    logic [TIME_BITS-1:0]   age;
    logic                   is_old;
    logic                   is_last;
    logic                   cur_free_vld;
    logic [IDX_BITS-1:0]    cur_free_idx;
    logic [CNT_BITS-1:0]    cnt_inc;
    logic                   out_free;

    ekvt_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_slot      = t_slot'(ram_rdata);
    assign chk_live     = r_chk_vld && r_valid[r_chk_idx];
    assign key_hit      = chk_live && (rd_slot.key == r_cmd.key);
    assign age          = r_cmd.now - rd_slot.stamp;
    assign is_old       = chk_live && (age >= i_expiry);
    assign is_last      = r_chk_idx == IDX_BITS'(ENTRIES - 1);
    assign cur_free_vld = r_free_vld || (r_chk_vld && !r_valid[r_chk_idx]);
    assign cur_free_idx = r_free_vld ? r_free_idx : r_chk_idx;
    assign cnt_inc      = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
    assign out_free     = !r_out_vld || i_out_ready;

    assign o_cmd_ready  = r_state == BS_IDLE;
    assign o_out_valid  = r_out_vld;
    assign o_out        = r_out;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_chk_vld  = r_chk_vld;
        n_chk_idx  = r_chk_idx;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_cnt      = r_cnt;
        n_res      = r_res;
        n_valid    = r_valid;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_chk_idx;
        ram_wdata  = '{key: r_cmd.key, value: r_cmd.value, stamp: r_cmd.now};
        ram_raddr  = r_addr[IDX_BITS-1:0];

        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd      = i_cmd;
                    n_addr     = '0;
                    n_chk_vld  = 1'b0;
                    n_free_vld = 1'b0;
                    n_cnt      = '0;
                    if (i_cmd.op == OP_NONE) begin
                        n_res   = '{status: ST_MISS, found_value: '0, purged_count: '0};
                        n_state = BS_DONE;
                    end else begin
                        n_state = BS_SCAN;
                    end
                end
            end
            BS_SCAN: begin
                // issue reads in order, data checked in the next cycle
                if (r_addr < CTR_BITS'(ENTRIES)) begin
                    n_addr    = r_addr + 1'b1;
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_addr[IDX_BITS-1:0];
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld) begin
                    n_free_vld = cur_free_vld;
                    n_free_idx = cur_free_idx;
                    unique case (r_cmd.op)
                        OP_ADD: begin
                            if (key_hit) begin
                                ram_we    = 1'b1;
                                n_res     = '{status: ST_UPDATED, found_value: '0,
                                              purged_count: '0};
                                n_chk_vld = 1'b0;
                                n_state   = BS_DONE;
                            end else if (is_last) begin
                                if (cur_free_vld) begin
                                    ram_we                = 1'b1;
                                    ram_waddr             = cur_free_idx;
                                    n_valid[cur_free_idx] = 1'b1;
                                    n_res = '{status: ST_INSERTED, found_value: '0,
                                              purged_count: '0};
                                end else begin
                                    n_res = '{status: ST_FULL, found_value: '0,
                                              purged_count: '0};
                                end
                                n_state = BS_DONE;
                            end
                        end
                        OP_FETCH: begin
                            if (key_hit) begin
                                ram_we    = 1'b1;
                                ram_wdata = '{key: rd_slot.key, value: rd_slot.value,
                                              stamp: r_cmd.now};
                                n_res     = '{status: ST_HIT, found_value: rd_slot.value,
                                              purged_count: '0};
                                n_chk_vld = 1'b0;
                                n_state   = BS_DONE;
                            end else if (is_last) begin
                                n_res   = '{status: ST_MISS, found_value: '0,
                                            purged_count: '0};
                                n_state = BS_DONE;
                            end
                        end
                        OP_PURGE: begin
                            if (is_old) begin
                                n_valid[r_chk_idx] = 1'b0;
                                n_cnt              = cnt_inc;
                            end
                            if (is_last) begin
                                n_res   = '{status: ST_PURGED, found_value: '0,
                                            purged_count: is_old ? cnt_inc : r_cnt};
                                n_state = BS_DONE;
                            end
                        end
                        default: begin
                            n_res   = '{status: ST_MISS, found_value: '0, purged_count: '0};
                            n_state = BS_DONE;
                        end
                    endcase
                end
            end
            BS_DONE: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_IDLE;
            r_chk_vld  <= 1'b0;
            r_free_vld <= 1'b0;
            r_valid    <= '0;
            r_out_vld  <= 1'b0;
            r_addr     <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_chk_vld  <= n_chk_vld;
            r_free_vld <= n_free_vld;
            r_valid    <= n_valid;
            r_out_vld  <= n_out_vld;
            r_addr     <= n_addr;
            r_cnt      <= n_cnt;
        end
        r_cmd      <= n_cmd;
        r_chk_idx  <= n_chk_idx;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

endmodule
`default_nettype wire
